### hdl/csh_pkg.sv
// ----------------------------------------------------------------------------
// csh_pkg
// Shared types, codes and helpers of the SYNC and heartbeat producer.
// ----------------------------------------------------------------------------
package csh_pkg;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_SET_STATE = 2'd1;
    localparam logic [1:0] OP_START_ALL = 2'd2;
    localparam logic [1:0] OP_RESET_ALL = 2'd3;

    localparam logic [1:0] ST_OFFLINE = 2'd0;
    localparam logic [1:0] ST_PREOP   = 2'd1;
    localparam logic [1:0] ST_OPER    = 2'd2;

    localparam logic [1:0] TX_IDLE  = 2'd0;
    localparam logic [1:0] TX_RETRY = 2'd1;
    localparam logic [1:0] TX_ERROR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HB_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ID     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 2'd3;

    localparam logic [10:0] ID_HB_BASE = 11'h700;
    localparam logic [10:0] ID_SYNC    = 11'h080;
    localparam logic [10:0] ID_NMT     = 11'h000;

    localparam logic [3:0] LEN_HB   = 4'd1;
    localparam logic [3:0] LEN_SYNC = 4'd0;
    localparam logic [3:0] LEN_NMT  = 4'd2;

    localparam logic [7:0] HB_BYTE_PREOP = 8'h7F;
    localparam logic [7:0] HB_BYTE_OPER  = 8'h05;
    localparam logic [7:0] CMD_START     = 8'h01;
    localparam logic [7:0] CMD_RESET     = 8'h81;

    localparam logic [6:0] NODE_ID_RESET     = 7'd1;
    localparam logic [7:0] RETRY_LIMIT_RESET = 8'd3;
    localparam logic [7:0] RETRY_MAX         = 8'hFF;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] retries;
    } csh_tx_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_time;
        logic [1:0]  new_state;
        logic        accept_first;
        logic        accept_second;
    } csh_item_t;

    typedef struct packed {
        logic        frame_valid;
        logic [10:0] can_id;
        logic [3:0]  frame_len;
        logic [7:0]  data_byte0;
        logic [7:0]  data_byte1;
        logic        sent_ok;
        logic        sync_sent;
        logic        command_status;
        logic [1:0]  tx_status;
        logic [1:0]  master_state_out;
        logic        last;
    } csh_result_t;

    typedef struct packed {
        csh_result_t first;
        csh_result_t second;
        logic        two;
    } csh_batch_t;

    function automatic csh_tx_t csh_attempt(csh_tx_t cur, logic accepted, logic [7:0] limit);
        csh_tx_t nxt;
        nxt = cur;
        if (accepted)
        begin
            nxt.status  = TX_IDLE;
            nxt.retries = 8'd0;
        end
        else
        begin
            if (cur.retries != RETRY_MAX)
            begin
                nxt.retries = cur.retries + 8'd1;
            end
            nxt.status = (nxt.retries > limit) ? TX_ERROR : TX_RETRY;
        end
        return nxt;
    endfunction

    function automatic csh_result_t csh_frame(logic [10:0] id, logic [3:0] len,
                                              logic [7:0] b0, logic ok);
        csh_result_t r;
        r                = '0;
        r.frame_valid    = 1'b1;
        r.can_id         = id;
        r.frame_len      = len;
        r.data_byte0     = b0;
        r.sent_ok        = ok;
        return r;
    endfunction

endpackage

### hdl/csh_core.sv
// ----------------------------------------------------------------------------
// csh_core
// Configuration and producer state; turns one registered item into one or
// two results and updates stamps, retries and master state when it fires.
// ----------------------------------------------------------------------------
module csh_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [csh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [csh_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  csh_pkg::csh_item_t                item,
    input  logic                              fire,
    output csh_pkg::csh_batch_t               batch
);

    logic [15:0]       hb_period_reg;
    logic [31:0]       sync_period_reg;
    logic [6:0]        node_id_reg;
    logic [7:0]        retry_limit_reg;
    logic [1:0]        master_state_reg;
    logic [1:0]        master_state_next;
    logic [31:0]       last_hb_reg;
    logic [31:0]       last_hb_next;
    logic [31:0]       last_sync_reg;
    logic [31:0]       last_sync_next;
    csh_pkg::csh_tx_t  tx_reg;
    csh_pkg::csh_tx_t  tx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_period_reg   <= '0;
            sync_period_reg <= '0;
            node_id_reg     <= csh_pkg::NODE_ID_RESET;
            retry_limit_reg <= csh_pkg::RETRY_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                csh_pkg::REG_HB_PERIOD:   hb_period_reg   <= cfg_data[15:0];
                csh_pkg::REG_SYNC_PERIOD: sync_period_reg <= cfg_data;
                csh_pkg::REG_NODE_ID:     node_id_reg     <= cfg_data[6:0];
                csh_pkg::REG_RETRY_LIMIT: retry_limit_reg <= cfg_data[7:0];
                default:                  hb_period_reg   <= hb_period_reg;
            endcase
        end
    end

    always_comb
    begin
        logic                 active;
        logic                 hb_due;
        logic                 sync_due;
        logic                 sync_acc;
        logic                 sync_ok;
        logic                 cmd_busy;
        logic [31:0]          hb_elapsed;
        logic [31:0]          sync_elapsed;
        logic [7:0]           hb_byte;
        csh_pkg::csh_tx_t     tx_a;
        csh_pkg::csh_result_t r0;
        csh_pkg::csh_result_t r1;

        master_state_next = master_state_reg;
        last_hb_next      = last_hb_reg;
        last_sync_next    = last_sync_reg;
        tx_next           = tx_reg;
        tx_a              = tx_reg;
        sync_ok           = 1'b0;
        cmd_busy          = 1'b0;
        r0                = '0;
        r1                = '0;
        batch.two         = 1'b0;

        hb_elapsed   = item.now_time - last_hb_reg;
        sync_elapsed = item.now_time - last_sync_reg;
        active       = (master_state_reg == csh_pkg::ST_PREOP)
                    || (master_state_reg == csh_pkg::ST_OPER);
        hb_due       = active && (hb_period_reg != 16'd0)
                    && (hb_elapsed >= {16'd0, hb_period_reg});
        sync_due     = (master_state_reg == csh_pkg::ST_OPER) && (sync_period_reg != 32'd0)
                    && (sync_elapsed >= sync_period_reg);
        sync_acc     = hb_due ? item.accept_second : item.accept_first;
        hb_byte      = (master_state_reg == csh_pkg::ST_PREOP) ? csh_pkg::HB_BYTE_PREOP
                                                               : csh_pkg::HB_BYTE_OPER;

        case (item.op)
            csh_pkg::OP_TICK:
            begin
                if (hb_due)
                begin
                    tx_a = csh_pkg::csh_attempt(tx_reg, item.accept_first, retry_limit_reg);
                    if (item.accept_first)
                    begin
                        last_hb_next = item.now_time;
                    end
                    r0 = csh_pkg::csh_frame(csh_pkg::ID_HB_BASE | {4'd0, node_id_reg},
                                            csh_pkg::LEN_HB, hb_byte, item.accept_first);
                end
                tx_next = tx_a;
                if (sync_due)
                begin
                    tx_next = csh_pkg::csh_attempt(tx_a, sync_acc, retry_limit_reg);
                    sync_ok = sync_acc;
                    if (sync_acc)
                    begin
                        last_sync_next = item.now_time;
                    end
                    if (hb_due)
                    begin
                        r1 = csh_pkg::csh_frame(csh_pkg::ID_SYNC, csh_pkg::LEN_SYNC,
                                                8'd0, sync_acc);
                        batch.two = 1'b1;
                    end
                    else
                    begin
                        r0 = csh_pkg::csh_frame(csh_pkg::ID_SYNC, csh_pkg::LEN_SYNC,
                                                8'd0, sync_acc);
                    end
                end
            end
            csh_pkg::OP_SET_STATE:
            begin
                if (item.new_state != 2'd3)
                begin
                    master_state_next = item.new_state;
                end
            end
            default:
            begin
                if (tx_reg.status == csh_pkg::TX_ERROR)
                begin
                    cmd_busy = 1'b1;
                end
                else
                begin
                    tx_next = csh_pkg::csh_attempt(tx_reg, item.accept_first, retry_limit_reg);
                    r0 = csh_pkg::csh_frame(csh_pkg::ID_NMT, csh_pkg::LEN_NMT,
                                            (item.op == csh_pkg::OP_START_ALL)
                                                ? csh_pkg::CMD_START : csh_pkg::CMD_RESET,
                                            item.accept_first);
                    if (item.accept_first)
                    begin
                        master_state_next = (item.op == csh_pkg::OP_START_ALL)
                                          ? csh_pkg::ST_OPER : csh_pkg::ST_PREOP;
                    end
                    else
                    begin
                        cmd_busy = 1'b1;
                    end
                end
            end
        endcase

        r0.sync_sent        = sync_ok;
        r0.command_status   = cmd_busy;
        r0.tx_status        = tx_next.status;
        r0.master_state_out = master_state_next;
        r0.last             = !batch.two;
        r1.sync_sent        = sync_ok;
        r1.command_status   = cmd_busy;
        r1.tx_status        = tx_next.status;
        r1.master_state_out = master_state_next;
        r1.last             = 1'b1;
        batch.first         = r0;
        batch.second        = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_state_reg <= csh_pkg::ST_OFFLINE;
            last_hb_reg      <= '0;
            last_sync_reg    <= '0;
            tx_reg           <= '{status: csh_pkg::TX_IDLE, retries: 8'd0};
        end
        else if (fire)
        begin
            master_state_reg <= master_state_next;
            last_hb_reg      <= last_hb_next;
            last_sync_reg    <= last_sync_next;
            tx_reg           <= tx_next;
        end
    end

endmodule

### hdl/csh_out_queue.sv
// ----------------------------------------------------------------------------
// csh_out_queue
// Two-slot result register; takes a batch of one or two results and hands
// them out one beat at a time.
// ----------------------------------------------------------------------------
module csh_out_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  csh_pkg::csh_batch_t   batch,
    input  logic                  load,
    output logic                  load_ok,
    output csh_pkg::csh_result_t  head,
    output logic                  head_valid,
    input  logic                  head_ready
);

    csh_pkg::csh_result_t slot0_reg;
    csh_pkg::csh_result_t slot1_reg;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;

    assign head_valid = (count_reg != 2'd0);
    assign head       = slot0_reg;
    assign load_ok    = (count_reg == 2'd0) || ((count_reg == 2'd1) && head_ready);

    always_comb
    begin
        count_next = count_reg;
        if (load)
        begin
            count_next = batch.two ? 2'd2 : 2'd1;
        end
        else if (head_valid && head_ready)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot0_reg <= batch.first;
            slot1_reg <= batch.second;
        end
        else if (head_valid && head_ready)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

### hdl/canopen_sync_heartbeat_producer.sv
// ----------------------------------------------------------------------------
// canopen_sync_heartbeat_producer
// Heartbeat, SYNC and global NMT producer of a CAN master node.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tuser op, s_tdata time/state/accepts
//  m_*     | out | m_tvalid/m_tready  | m_tuser frame_valid, m_tdata frame
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An item is held in the input register until the output register can take
// its results, which are loaded there when the item fires. One item per cycle
// while each item makes one result and m_tready is high; a tick that sends both
// heartbeat and SYNC holds the output register for two beats.
// Reset clears state at once; cfg_ready is always high.
// ----------------------------------------------------------------------------
module canopen_sync_heartbeat_producer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [1:0]                        s_tuser,  // op[1:0]
    // now_time[31:0], new_state[33:32], accept_first[34], accept_second[35]
    input  logic [csh_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic                              m_tlast,
    output logic                              m_tuser,  // frame_valid[0]
    // can_id[10:0], frame_len[14:11], data_byte0[22:15], data_byte1[30:23],
    // sent_ok[31], sync_sent[32], command_status[33], tx_status[35:34],
    // master_state_out[37:36]
    output logic [csh_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [csh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [csh_pkg::CFG_DATA_W-1:0]    cfg_data
);

    csh_pkg::csh_item_t   item_reg;
    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic                 load_ok;
    logic                 fire;
    csh_pkg::csh_batch_t  batch;
    csh_pkg::csh_result_t head;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && load_ok;
    assign s_tready  = !in_valid_reg || load_ok;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.op            <= s_tuser;
            item_reg.now_time      <= s_tdata[31:0];
            item_reg.new_state     <= s_tdata[33:32];
            item_reg.accept_first  <= s_tdata[34];
            item_reg.accept_second <= s_tdata[35];
        end
    end

    csh_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_reg),
        .fire      (fire),
        .batch     (batch)
    );

    csh_out_queue u_out_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .batch      (batch),
        .load       (fire),
        .load_ok    (load_ok),
        .head       (head),
        .head_valid (m_tvalid),
        .head_ready (m_tready)
    );

    assign m_tlast = head.last;
    assign m_tuser = head.frame_valid;
    assign m_tdata = {2'b00, head.master_state_out, head.tx_status, head.command_status,
                      head.sync_sent, head.sent_ok, head.data_byte1, head.data_byte0,
                      head.frame_len, head.can_id};

    a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("result missing after item fired");

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !load_ok) |=> in_valid_reg)
        else $error("stalled item dropped");

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
        else $error("second result of a tick missing");

    a_no_fire_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !fire)
        else $error("batch loaded over a pending pair");

endmodule

### test/canopen_sync_heartbeat_producer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canopen_sync_heartbeat_producer_test
// Self-checking bench for the heartbeat, SYNC and global NMT producer.
//
// A queue of pending items feeds a clocked stream driver. The monitor tracks
// the producer's state on every accepted input beat. It predicts the frame
// beats and checks each output beat field by field. A short directed
// sequence comes first. Random runs follow under several register settings
// and three idle mixes on the two stream sides. The random runs include a
// long run of refused frames aimed at saturating the retry counter.
// ----------------------------------------------------------------------------
module canopen_sync_heartbeat_producer_test;

    import csh_pkg::*;

    localparam int IDLE_LIMIT = 1000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [1:0]            s_tuser = '0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  m_tlast;
    logic                  m_tuser;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    canopen_sync_heartbeat_producer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // producer registers and state as seen by the predictor
    logic [15:0] hb_period    = '0;
    logic [31:0] sync_period  = '0;
    logic [6:0]  own_node     = NODE_ID_RESET;
    logic [7:0]  retry_limit  = RETRY_LIMIT_RESET;
    logic [1:0]  master_state = ST_OFFLINE;
    logic [31:0] hb_stamp     = '0;
    logic [31:0] sync_stamp   = '0;
    logic [1:0]  tx_state     = TX_IDLE;
    logic [7:0]  retries      = '0;

    csh_item_t   items_waiting[$];
    csh_result_t frames_due[$];
    logic [31:0] clock_now = '0;

    int items_loaded   = 0;
    int items_accepted = 0;
    int beats_checked  = 0;
    int cfg_writes     = 0;
    int syncs_out      = 0;
    int error_entries  = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;
    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    bit in_beat = 1'b0;

    csh_item_t   feed_item;
    csh_result_t got;
    csh_result_t want;

    function automatic void note_attempt(logic accepted);
        if (accepted)
        begin
            tx_state = TX_IDLE;
            retries  = '0;
        end
        else
        begin
            if (retries != RETRY_MAX)
            begin
                retries = retries + 8'd1;
            end
            if (retries > retry_limit)
            begin
                if (tx_state != TX_ERROR)
                begin
                    error_entries++;
                end
                tx_state = TX_ERROR;
            end
            else
            begin
                tx_state = TX_RETRY;
            end
        end
    endfunction

    function automatic csh_result_t make_frame(logic [10:0] id, logic [3:0] len,
                                               logic [7:0] byte0, logic accepted);
        csh_result_t f;
        f             = '0;
        f.frame_valid = 1'b1;
        f.can_id      = id;
        f.frame_len   = len;
        f.data_byte0  = byte0;
        f.sent_ok     = accepted;
        return f;
    endfunction

    function automatic void predict_step(logic [1:0] op, logic [31:0] now_t, logic [1:0] ns,
                                         logic acc_a, logic acc_b);
        csh_result_t beats [0:1];
        logic [1:0]  accs;
        logic [31:0] elapsed;
        logic        ok;
        logic        synced;
        logic        busy;
        int          n;
        beats[0] = '0;
        beats[1] = '0;
        accs     = {acc_b, acc_a};
        synced   = 1'b0;
        busy     = 1'b0;
        n        = 0;
        case (op)
            OP_TICK:
            begin
                if (master_state == ST_PREOP || master_state == ST_OPER)
                begin
                    elapsed = now_t - hb_stamp;
                    if (hb_period != '0 && elapsed >= {16'd0, hb_period})
                    begin
                        ok = accs[n];
                        note_attempt(ok);
                        beats[n] = make_frame(ID_HB_BASE | {4'd0, own_node}, LEN_HB,
                            (master_state == ST_PREOP) ? HB_BYTE_PREOP : HB_BYTE_OPER, ok);
                        if (ok)
                        begin
                            hb_stamp = now_t;
                        end
                        n++;
                    end
                    elapsed = now_t - sync_stamp;
                    if (master_state == ST_OPER && sync_period != '0 && elapsed >= sync_period)
                    begin
                        ok = accs[n];
                        note_attempt(ok);
                        beats[n] = make_frame(ID_SYNC, LEN_SYNC, 8'h00, ok);
                        if (ok)
                        begin
                            sync_stamp = now_t;
                            synced     = 1'b1;
                            syncs_out++;
                        end
                        n++;
                    end
                end
            end
            OP_SET_STATE:
            begin
                if (ns <= ST_OPER)
                begin
                    master_state = ns;
                end
            end
            default:
            begin
                if (tx_state == TX_ERROR)
                begin
                    busy = 1'b1;
                end
                else
                begin
                    ok = accs[0];
                    note_attempt(ok);
                    beats[0] = make_frame(ID_NMT, LEN_NMT,
                        (op == OP_START_ALL) ? CMD_START : CMD_RESET, ok);
                    if (ok)
                    begin
                        master_state = (op == OP_START_ALL) ? ST_OPER : ST_PREOP;
                    end
                    else
                    begin
                        busy = 1'b1;
                    end
                end
            end
        endcase
        if (n == 0)
        begin
            n = 1;
        end
        for (int k = 0; k < n; k++)
        begin
            beats[k].sync_sent        = synced;
            beats[k].command_status   = busy;
            beats[k].tx_status        = tx_state;
            beats[k].master_state_out = master_state;
            beats[k].last             = (k == n - 1);
            frames_due.push_back(beats[k]);
        end
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_HB_PERIOD:   hb_period   = value[15:0];
            REG_SYNC_PERIOD: sync_period = value;
            REG_NODE_ID:     own_node    = value[6:0];
            REG_RETRY_LIMIT: retry_limit = value[7:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
            mismatches++;
        end
    endfunction

    // input driver: hold the beat until accepted, then advance or idle
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_beat)
        begin
            if (items_waiting.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                feed_item = items_waiting.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= feed_item.op;
                s_tdata  <= {4'd0, feed_item.accept_second, feed_item.accept_first,
                             feed_item.new_state, feed_item.now_time};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        m_tready <= rst_n && ($urandom_range(99) >= receiver_stall_pct);
    end

    // monitor: predict on input beats, check output beats, watch for hangs
    always @(posedge clk)
    begin
        in_beat = rst_n && s_tvalid && s_tready;
        if (in_beat)
        begin
            predict_step(s_tuser, s_tdata[31:0], s_tdata[33:32], s_tdata[34], s_tdata[35]);
            items_accepted++;
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            apply_reg(cfg_index, cfg_data);
            cfg_writes++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.frame_valid      = m_tuser;
            got.can_id           = m_tdata[10:0];
            got.frame_len        = m_tdata[14:11];
            got.data_byte0       = m_tdata[22:15];
            got.data_byte1       = m_tdata[30:23];
            got.sent_ok          = m_tdata[31];
            got.sync_sent        = m_tdata[32];
            got.command_status   = m_tdata[33];
            got.tx_status        = m_tdata[35:34];
            got.master_state_out = m_tdata[37:36];
            got.last             = m_tlast;
            if (frames_due.size() == 0)
            begin
                $error("unexpected output beat: tdata 0x%0h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = frames_due.pop_front();
                check_field("frame_valid", want.frame_valid, got.frame_valid);
                check_field("can_id", want.can_id, got.can_id);
                check_field("frame_len", want.frame_len, got.frame_len);
                check_field("data_byte0", want.data_byte0, got.data_byte0);
                check_field("data_byte1", want.data_byte1, got.data_byte1);
                check_field("sent_ok", want.sent_ok, got.sent_ok);
                check_field("sync_sent", want.sync_sent, got.sync_sent);
                check_field("command_status", want.command_status, got.command_status);
                check_field("tx_status", want.tx_status, got.tx_status);
                check_field("master_state_out", want.master_state_out, got.master_state_out);
                check_field("last", want.last, got.last);
            end
            beats_checked++;
        end
        if (in_beat || (cfg_valid && cfg_ready) || (m_tvalid && m_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, frames_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_item(input logic [1:0] op, input logic [31:0] now_t,
                             input logic [1:0] ns, input logic acc_a, input logic acc_b);
        csh_item_t it;
        it.op            = op;
        it.now_time      = now_t;
        it.new_state     = ns;
        it.accept_first  = acc_a;
        it.accept_second = acc_b;
        items_waiting.push_back(it);
        items_loaded++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (items_accepted != items_loaded || frames_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic program_regs(input logic [15:0] hb, input logic [31:0] sync,
                                input logic [6:0] node, input logic [7:0] limit);
        write_reg(REG_HB_PERIOD, {16'd0, hb});
        write_reg(REG_SYNC_PERIOD, sync);
        write_reg(REG_NODE_ID, {25'd0, node});
        write_reg(REG_RETRY_LIMIT, {24'd0, limit});
    endtask

    // mostly ticks on an advancing clock, mixed with state and NMT commands
    task automatic queue_random(input int count, input int accept_pct, input int tick_pct,
                                input int jump_max);
        logic [1:0]  op;
        logic [31:0] stamp;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < tick_pct)
            begin
                op = OP_TICK;
                if ($urandom_range(99) < 3)
                begin
                    clock_now = $urandom;
                end
                else
                begin
                    clock_now = clock_now + $urandom_range(jump_max);
                end
                stamp = clock_now;
            end
            else
            begin
                case ($urandom_range(3))
                    0, 1:    op = OP_SET_STATE;
                    2:       op = OP_START_ALL;
                    default: op = OP_RESET_ALL;
                endcase
                stamp = $urandom;
            end
            push_item(op, stamp, 2'($urandom_range(3)), $urandom_range(99) < accept_pct,
                      $urandom_range(99) < accept_pct);
        end
    endtask

    task automatic run_chunk(input logic [15:0] hb, input logic [31:0] sync,
                             input logic [6:0] node, input logic [7:0] limit,
                             input int accept_pct, input int tick_pct,
                             input int jump_max, input int count);
        program_regs(hb, sync, node, limit);
        push_item(OP_SET_STATE, clock_now, ST_OPER, 1'b0, 1'b0);
        queue_random(count, accept_pct, tick_pct, jump_max);
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sender_idle_pct    = 8;
        receiver_stall_pct = 83;
        program_regs(16'd100, 32'd50, 7'd127, 8'd1);
        push_item(OP_TICK, 32'h0000_0000, ST_OFFLINE, 1'b0, 1'b0);
        push_item(OP_SET_STATE, 32'hFFFF_FFFF, 2'd3, 1'b1, 1'b1);
        push_item(OP_SET_STATE, 32'h0000_0000, ST_PREOP, 1'b0, 1'b0);
        push_item(OP_TICK, 32'd100, ST_OFFLINE, 1'b1, 1'b0);
        push_item(OP_TICK, 32'd150, ST_OFFLINE, 1'b1, 1'b1);
        push_item(OP_SET_STATE, 32'h0000_0000, ST_OPER, 1'b0, 1'b0);
        push_item(OP_TICK, 32'd200, ST_OFFLINE, 1'b1, 1'b1);
        push_item(OP_TICK, 32'd300, ST_OFFLINE, 1'b0, 1'b0);
        push_item(OP_START_ALL, 32'h0000_0000, ST_OFFLINE, 1'b1, 1'b1);
        push_item(OP_TICK, 32'd300, ST_OFFLINE, 1'b1, 1'b0);
        push_item(OP_RESET_ALL, 32'h0000_0000, ST_OFFLINE, 1'b1, 1'b0);
        push_item(OP_START_ALL, 32'h0000_0000, ST_OFFLINE, 1'b0, 1'b1);
        push_item(OP_START_ALL, 32'h0000_0000, ST_OFFLINE, 1'b1, 1'b0);
        push_item(OP_TICK, 32'hFFFF_FFF0, ST_OFFLINE, 1'b1, 1'b1);
        push_item(OP_TICK, 32'h0000_0040, ST_OFFLINE, 1'b1, 1'b1);
        push_item(OP_TICK, 32'h0000_0060, ST_OFFLINE, 1'b1, 1'b1);
        push_item(OP_SET_STATE, 32'h0000_0000, ST_OFFLINE, 1'b0, 1'b0);
        push_item(OP_TICK, 32'h7FFF_FFFF, ST_OPER, 1'b1, 1'b1);
        push_item(OP_RESET_ALL, 32'h0000_0000, ST_OFFLINE, 1'b0, 1'b0);
        push_item(OP_RESET_ALL, 32'h0000_0000, ST_OFFLINE, 1'b0, 1'b0);
        push_item(OP_TICK, 32'h8000_0000, ST_OFFLINE, 1'b1, 1'b1);
        push_item(OP_SET_STATE, 32'h0000_0000, ST_OPER, 1'b0, 1'b0);
        push_item(OP_TICK, 32'hFFFF_FFFF, ST_OFFLINE, 1'b1, 1'b1);
        clock_now = 32'hFFFF_FFFF;
        drain();

        run_chunk(16'd40, 32'd25, 7'd5, 8'd3, 75, 70, 30, 180);

        sender_idle_pct    = 83;
        receiver_stall_pct = 8;
        run_chunk(16'hFFFF, 32'hFFFF_FFFF, 7'd0, 8'd0, 70, 75, 70000, 140);
        run_chunk(16'd0, 32'd7, 7'd64, 8'd2, 60, 70, 10, 140);

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        // nearly every frame refused: aim to push the retry counter into saturation
        run_chunk(16'd12, 32'd9, 7'd99, 8'd255, 2, 90, 24, 260);
        run_chunk(16'd1, 32'd0, 7'd127, 8'd0, 80, 70, 3, 110);

        $display("Run covered %0d input items, %0d output beats, %0d register writes",
                 items_accepted, beats_checked, cfg_writes);
        $display("  with %0d SYNC frames sent and %0d entries into transmit error",
                 syncs_out, error_entries);
        if (mismatches == 0 && frames_due.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
